### hdl/detection_row_decoder_unit_defines.svh
// assertion macros for the detection row decoder checker
// no dependencies; included by the checker file only
`ifndef DETECTION_ROW_DECODER_UNIT_DEFINES_SVH
`define DETECTION_ROW_DECODER_UNIT_DEFINES_SVH

// check that is switched off while reset is held
`define DRD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("detection_row_decoder_unit: check failed");

// check that also runs during reset
`define DRD_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("detection_row_decoder_unit: reset check failed");

`endif

### hdl/drd_pkg.sv
// shared types, constants and helpers of the detection row decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package drd_pkg;

    localparam int BOX_FIELDS      = 5;
    localparam int MAX_CLASSES_DEF = 128;
    localparam int CLASS_LIMIT     = 128;
    localparam int QUEUE_DEPTH     = 2;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [7:0]  NUM_CLASSES_RST = 8'd80;
    localparam logic [16:0] THRESHOLD_RST   = 17'd16384;
    localparam logic [16:0] SCORE_ONE       = 17'd65536;

    // row positions of the box fields
    localparam logic [7:0] POS_CX  = 8'd0;
    localparam logic [7:0] POS_CY  = 8'd1;
    localparam logic [7:0] POS_W   = 8'd2;
    localparam logic [7:0] POS_H   = 8'd3;
    localparam logic [7:0] POS_OBJ = 8'd4;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_CLASSES     = 1'b0;
    localparam logic REG_SCORE_THRESHOLD = 1'b1;

    typedef struct packed {
        logic signed [31:0] value;
        logic               frame_last;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic        [16:0] score;
        logic        [6:0]  class_id;
    } t_result;

    typedef struct packed {
        logic [7:0]  num_classes;
        logic [16:0] score_threshold;
    } t_cfg;

    // candidate handed from the row parser to the decode stage
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic        [30:0] obj;
        logic        [30:0] best;
        logic        [6:0]  class_id;
    } t_cand;

    // integer part of a q16.16 value, toward zero
    function automatic logic signed [15:0] int_part(input logic [31:0] v);
        logic signed [15:0] fl;
        fl = v[31:16];
        if (v[31] && (v[15:0] != 16'd0)) begin
            fl = fl + 16'sd1;
        end
        return fl;
    endfunction

    // halve toward zero
    function automatic logic signed [15:0] half_tz(input logic signed [15:0] x);
        logic signed [15:0] t;
        t = x + $signed({15'b0, x[15]});
        return t >>> 1;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] x);
        logic signed [15:0] r;
        if (x > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (x < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/drd_queue.sv
// small register queue, payload type set by parameter
// depends on drd_pkg for the default depth
`timescale 1ns / 1ps
`default_nettype none

module drd_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = drd_pkg::QUEUE_DEPTH
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  T     i_push_data,
    output logic o_full,
    input  wire  i_pop,
    output T     o_pop_data,
    output logic o_empty
);
    import drd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    T              r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/drd_front.sv
// row parser: tracks the row position, holds the box values and the running
// class argmax, and raises a candidate at row end above threshold. depends on drd_pkg
`timescale 1ns / 1ps
`default_nettype none

module drd_front #(
    parameter int MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  drd_pkg::t_cfg    i_cfg,
    input  wire              i_accept,
    input  drd_pkg::t_in_item i_item,
    output logic             o_cand_push,
    output drd_pkg::t_cand   o_cand
);
    import drd_pkg::*;

    localparam int         CAP   = (MAX_CLASSES < CLASS_LIMIT) ? MAX_CLASSES : CLASS_LIMIT;
    localparam logic [7:0] CAP_W = 8'(CAP);

    logic [7:0]  r_pos;
    logic [31:0] r_cx;
    logic [31:0] r_cy;
    logic [31:0] r_w;
    logic [31:0] r_h;
    logic [31:0] r_obj;
    logic [31:0] r_best;
    logic [6:0]  r_best_class;

    logic [7:0]  n_pos;
    logic [31:0] n_best;
    logic [6:0]  n_best_class;
    logic [7:0]  classes;
    logic [7:0]  row_end;
    logic [7:0]  class_pos;
    logic        row_end_hit;
    logic        is_class;
    logic        beats;
    logic        keep;

    always_comb begin
        if (i_cfg.num_classes == 8'd0) begin
            classes = 8'd1;
        end else if (i_cfg.num_classes > CAP_W) begin
            classes = CAP_W;
        end else begin
            classes = i_cfg.num_classes;
        end
    end

    assign row_end     = POS_OBJ + classes;
    assign row_end_hit = (r_pos >= row_end);
    assign is_class    = (r_pos >= 8'(BOX_FIELDS));
    assign class_pos   = r_pos - 8'(BOX_FIELDS);
    assign beats       = is_class && (i_item.value > $signed(r_best));
    // threshold is zero-extended, so this is a signed objectness compare
    assign keep        = $signed(r_obj) > $signed({15'b0, i_cfg.score_threshold});

    assign n_best       = beats ? i_item.value : r_best;
    assign n_best_class = beats ? class_pos[6:0] : r_best_class;

    always_comb begin
        n_pos = row_end_hit ? 8'd0 : r_pos + 8'd1;
        if (i_item.frame_last) begin
            n_pos = 8'd0;
        end
    end

    // best score never goes negative, so bit 31 is always clear here
    assign o_cand_push     = i_accept && row_end_hit && keep;
    assign o_cand.cx       = int_part(r_cx);
    assign o_cand.cy       = int_part(r_cy);
    assign o_cand.w        = int_part(r_w);
    assign o_cand.h        = int_part(r_h);
    assign o_cand.obj      = r_obj[30:0];
    assign o_cand.best     = n_best[30:0];
    assign o_cand.class_id = n_best_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_cx         <= '0;
            r_cy         <= '0;
            r_w          <= '0;
            r_h          <= '0;
            r_obj        <= '0;
            r_best       <= '0;
            r_best_class <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            unique case (r_pos)
                POS_CX:  r_cx <= i_item.value;
                POS_CY:  r_cy <= i_item.value;
                POS_W:   r_w  <= i_item.value;
                POS_H:   r_h  <= i_item.value;
                POS_OBJ: begin
                    r_obj        <= i_item.value;
                    r_best       <= '0;
                    r_best_class <= '0;
                end
                default: begin
                    r_best       <= n_best;
                    r_best_class <= n_best_class;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/drd_back.sv
// decode stage: corner box, saturation and score product for one candidate
// depends on drd_pkg
`timescale 1ns / 1ps
`default_nettype none

module drd_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cand_valid,
    input  drd_pkg::t_cand  i_cand,
    output logic            o_cand_pop,
    output logic            o_res_push,
    output drd_pkg::t_result o_res,
    input  wire             i_res_full
);
    import drd_pkg::*;

    logic               r_s1_valid;
    logic [61:0]        r_s1_prod;
    logic signed [15:0] r_s1_left;
    logic signed [15:0] r_s1_top;
    logic signed [15:0] r_s1_w;
    logic signed [15:0] r_s1_h;
    logic [6:0]         r_s1_class;

    logic               s1_ready;
    logic [61:0]        prod;
    logic signed [15:0] half_w;
    logic signed [15:0] half_h;
    logic signed [16:0] left_wide;
    logic signed [16:0] top_wide;

    assign s1_ready   = !r_s1_valid || !i_res_full;
    assign o_cand_pop = i_cand_valid && s1_ready;
    assign o_res_push = r_s1_valid && !i_res_full;

    assign prod      = i_cand.obj * i_cand.best;
    assign half_w    = half_tz(i_cand.w);
    assign half_h    = half_tz(i_cand.h);
    assign left_wide = $signed({i_cand.cx[15], i_cand.cx})
                     - $signed({half_w[15], half_w});
    assign top_wide  = $signed({i_cand.cy[15], i_cand.cy})
                     - $signed({half_h[15], half_h});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_cand_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cand_pop) begin
            r_s1_prod  <= prod;
            r_s1_left  <= sat16(left_wide);
            r_s1_top   <= sat16(top_wide);
            r_s1_w     <= i_cand.w;
            r_s1_h     <= i_cand.h;
            r_s1_class <= i_cand.class_id;
        end
    end

    // score is the product in q1.16, capped at one
    always_comb begin
        o_res.left       = r_s1_left;
        o_res.top        = r_s1_top;
        o_res.box_width  = r_s1_w;
        o_res.box_height = r_s1_h;
        o_res.class_id   = r_s1_class;
        if (r_s1_prod[61:16] > 46'(SCORE_ONE)) begin
            o_res.score = SCORE_ONE;
        end else begin
            o_res.score = r_s1_prod[32:16];
        end
    end

endmodule

`default_nettype wire

### hdl/detection_row_decoder_unit.sv
// top level of the detection row decoder: config registers, row parser,
// candidate queue, decode stage and result queue. depends on drd_pkg
//
//   channel   direction  handshake          payload
//   input     in         push / full        i_item (value, frame_last)
//   result    out        pop / empty        o_result (box, score, class_id)
//   config    in/out     psel penable pwrite paddr, pwdata, prdata
//
// one value is taken every cycle while full is low; the row parser decides in that cycle
// a candidate enters the candidate queue at the edge that takes the row's last
// value, then passes through the multiply stage register into the result queue
// before it is visible on o_result; a full result queue can hold it back
// full rises only when the candidate queue holds two waiting candidates
// a stalled pop backs up through the result queue and the multiply stage
// synchronous active low reset empties all queues, registers take defaults
`timescale 1ns / 1ps
`default_nettype none

module detection_row_decoder_unit #(
    parameter int MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       push,
    output logic                      full,
    input  drd_pkg::t_in_item         i_item,
    output logic                      empty,
    input  wire                       pop,
    output drd_pkg::t_result          o_result,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire [drd_pkg::APB_AW-1:0] paddr,
    input  wire [drd_pkg::APB_DW-1:0] pwdata,
    output logic [drd_pkg::APB_DW-1:0] prdata,
    output logic                      pready
);
    import drd_pkg::*;

    logic [7:0]  r_num_classes;
    logic [16:0] r_score_threshold;

    t_cfg    cfg;
    logic    cfg_write;
    logic    accept;
    logic    cand_push;
    t_cand   cand_in;
    t_cand   cand_head;
    logic    cand_empty;
    logic    cand_pop;
    logic    res_push;
    t_result res_in;
    logic    res_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes     <= NUM_CLASSES_RST;
            r_score_threshold <= THRESHOLD_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_NUM_CLASSES:     r_num_classes     <= pwdata[7:0];
                REG_SCORE_THRESHOLD: r_score_threshold <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_CLASSES:     prdata = {24'b0, r_num_classes};
            REG_SCORE_THRESHOLD: prdata = {15'b0, r_score_threshold};
            default:             prdata = '0;
        endcase
    end

    assign cfg.num_classes     = r_num_classes;
    assign cfg.score_threshold = r_score_threshold;

    assign accept = push && !full;

    drd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cand_push (cand_push),
        .o_cand      (cand_in)
    );

    drd_queue #(
        .T     (t_cand),
        .DEPTH (QUEUE_DEPTH)
    ) u_cand_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (cand_push),
        .i_push_data (cand_in),
        .o_full      (full),
        .i_pop       (cand_pop),
        .o_pop_data  (cand_head),
        .o_empty     (cand_empty)
    );

    drd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_valid (!cand_empty),
        .i_cand       (cand_head),
        .o_cand_pop   (cand_pop),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full)
    );

    drd_queue #(
        .T     (t_result),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_push),
        .i_push_data (res_in),
        .o_full      (res_full),
        .i_pop       (pop),
        .o_pop_data  (o_result),
        .o_empty     (empty)
    );

endmodule

`default_nettype wire

### hdl/drd_checker.sv
// port-level checks of the detection row decoder, bound to the top level
// depends on drd_pkg and detection_row_decoder_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "detection_row_decoder_unit_defines.svh"

module drd_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              push,
    input wire              full,
    input wire              pop,
    input wire              empty,
    input drd_pkg::t_result o_result,
    input wire              pready
);
    import drd_pkg::*;

    // queues come out of reset empty on both sides
    `DRD_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n |=> empty && !full)
    `DRD_ASSERT(a_pready_high, i_clk, i_rst_n, pready)
    `DRD_ASSERT(a_head_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_result))
    `DRD_ASSERT(a_score_cap, i_clk, i_rst_n, !empty |-> o_result.score <= SCORE_ONE)

endmodule

bind detection_row_decoder_unit drd_checker u_drd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result),
    .pready   (pready)
);

`default_nettype wire

### test/detection_row_decoder_unit_checker.sv
// checker for detection_row_decoder_unit: watches the request, result and apb
// channels, predicts decoded boxes and compares them. depends on drd_pkg
`timescale 1ns / 1ps

module detection_row_decoder_unit_checker #(
    parameter int MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  wire                        i_full,
    input  drd_pkg::t_in_item          i_item,
    input  wire                        i_empty,
    input  wire                        i_pop,
    input  drd_pkg::t_result           i_result,
    input  wire                        i_psel,
    input  wire                        i_penable,
    input  wire                        i_pwrite,
    input  wire [drd_pkg::APB_AW-1:0]  i_paddr,
    input  wire [drd_pkg::APB_DW-1:0]  i_pwdata,
    input  wire [drd_pkg::APB_DW-1:0]  i_prdata,
    input  wire                        i_pready,
    output int                         o_errors,
    output int                         o_pending
);
    import drd_pkg::*;

    localparam int PRINT_CAP = 100;

    // register copies
    logic [7:0]  classes_reg;
    logic [16:0] thresh_reg;

    // row state
    logic [7:0]         row_pos;
    logic signed [31:0] held_cx;
    logic signed [31:0] held_cy;
    logic signed [31:0] held_w;
    logic signed [31:0] held_h;
    logic signed [31:0] held_obj;
    logic signed [31:0] best_val;
    logic [6:0]         best_idx;

    t_result pending_boxes[$];
    int      err_count = 0;
    int      pending_count = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_count;

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("%0t ns checker: %s", $time, msg);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    function automatic logic signed [15:0] clamp16(input longint x);
        if (x > 32767) begin
            return 16'sh7FFF;
        end else if (x < -32768) begin
            return 16'sh8000;
        end
        return 16'(x);
    endfunction

    // advances the row state by one value; returns 1 when a box comes out
    function automatic bit decode_value(input t_in_item it, output t_result box);
        int unsigned n_used;
        int unsigned row_end;
        longint      cx;
        longint      cy;
        longint      w;
        longint      h;
        longint      prod;
        longint      sc;
        bit          hit;
        hit = 1'b0;
        box = '0;
        n_used = 32'(classes_reg);
        if (n_used < 1) n_used = 1;
        if (n_used > MAX_CLASSES) n_used = MAX_CLASSES;
        if (n_used > CLASS_LIMIT) n_used = CLASS_LIMIT;
        row_end = BOX_FIELDS - 1 + n_used;
        case (row_pos)
            POS_CX: held_cx = it.value;
            POS_CY: held_cy = it.value;
            POS_W:  held_w = it.value;
            POS_H:  held_h = it.value;
            POS_OBJ: begin
                held_obj = it.value;
                best_val = '0;
                best_idx = '0;
            end
            default: begin
                if ($signed(it.value) > best_val) begin
                    best_val = it.value;
                    best_idx = 7'(row_pos - BOX_FIELDS);
                end
            end
        endcase
        if (row_pos >= row_end) begin
            if (longint'(held_obj) > longint'(thresh_reg)) begin
                cx = longint'(held_cx) / 65536;
                cy = longint'(held_cy) / 65536;
                w = longint'(held_w) / 65536;
                h = longint'(held_h) / 65536;
                // best score never drops below zero, objectness is above threshold
                prod = longint'(held_obj) * longint'(best_val);
                sc = prod >>> 16;
                if (sc > 65536) sc = 65536;
                box.left = clamp16(cx - w / 2);
                box.top = clamp16(cy - h / 2);
                box.box_width = clamp16(w);
                box.box_height = clamp16(h);
                box.score = 17'(sc);
                box.class_id = best_idx;
                hit = 1'b1;
            end
            row_pos = '0;
        end else begin
            row_pos = row_pos + 8'd1;
        end
        if (it.frame_last) row_pos = '0;
        return hit;
    endfunction

    always @(posedge i_clk) begin
        t_result     want;
        t_result     box;
        logic [31:0] read_back;
        if (!i_rst_n) begin
            classes_reg = NUM_CLASSES_RST;
            thresh_reg = THRESHOLD_RST;
            row_pos = '0;
            held_cx = '0;
            held_cy = '0;
            held_w = '0;
            held_h = '0;
            held_obj = '0;
            best_val = '0;
            best_idx = '0;
            pending_boxes.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_SCORE_THRESHOLD) begin
                        thresh_reg = i_pwdata[16:0];
                    end else begin
                        classes_reg = i_pwdata[7:0];
                    end
                end else begin
                    read_back = (i_paddr[2] == REG_SCORE_THRESHOLD) ?
                                32'(thresh_reg) : 32'(classes_reg);
                    check_field("register read", i_prdata, read_back);
                end
            end
            if (i_pop && !i_empty) begin
                if (pending_boxes.size() == 0) begin
                    report_mismatch("box popped with nothing pending");
                end else begin
                    want = pending_boxes.pop_front();
                    check_field("left", 32'(i_result.left), 32'(want.left));
                    check_field("top", 32'(i_result.top), 32'(want.top));
                    check_field("box_width", 32'(i_result.box_width),
                                32'(want.box_width));
                    check_field("box_height", 32'(i_result.box_height),
                                32'(want.box_height));
                    check_field("score", 32'(i_result.score), 32'(want.score));
                    check_field("class_id", 32'(i_result.class_id),
                                32'(want.class_id));
                end
            end
            if (i_push && !i_full) begin
                if (decode_value(i_item, box)) begin
                    pending_boxes = {pending_boxes, box};
                end
            end
        end
        pending_count <= pending_boxes.size();
    end

endmodule

### test/detection_row_decoder_unit_tb.sv
// testbench top for detection_row_decoder_unit: clock, reset, apb writes,
// tensor value stimulus and the verdict. depends on drd_pkg and the checker
`timescale 1ns / 1ps

module detection_row_decoder_unit_tb;
    import drd_pkg::*;

    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_CYCLES = 80;
    localparam int NUM_PHASES   = 7;
    localparam int STALL_PHASE  = 0;
    localparam int RANDOM_TH_PHASE = 5;
    localparam int STEADY_PHASE = 6;

    localparam logic [APB_AW-1:0] ADDR_NUM_CLASSES = {REG_NUM_CLASSES, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_THRESHOLD   = {REG_SCORE_THRESHOLD, 2'b00};

    localparam int PHASE_CLASSES [NUM_PHASES] = '{1, 0, 128, 255, 3, 7, 16};
    localparam int PHASE_THRESH  [NUM_PHASES] = '{0, 65536, 16384, 100, 131071, 0, 32768};
    localparam int PHASE_ITEMS   [NUM_PHASES] = '{200, 120, 140, 100, 120, 180, 160};

    localparam logic [31:0] EDGE_VALUES [4] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF
    };

    // two class scores per row: extremes with a tie, fractions with a
    // negative score, objectness equal to threshold, then a cut frame
    localparam logic [31:0] CORNER_VALUES [24] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'hFFFE_8000, 32'h0000_8000, 32'hFFFC_C000, 32'h0005_C000,
        32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000,
        32'h0064_0000, 32'h00C8_0000, 32'h0011_0000, 32'hFFEF_0000,
        32'h0000_0000, 32'h0000_4000, 32'h0001_0000,
        32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                pop = 1'b0;
    t_in_item            i_item = '0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic                full;
    logic                empty;
    t_result             o_result;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int                  errors;
    int                  pending;

    bit steady = 1'b0;
    bit stall_req = 1'b0;
    int phase_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    detection_row_decoder_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    detection_row_decoder_unit_checker #(
        .MAX_CLASSES (MAX_CLASSES_DEF)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_item    (i_item),
        .i_empty   (empty),
        .i_pop     (pop),
        .i_result  (o_result),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_prdata  (prdata),
        .i_pready  (pready),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // write a register, read it back, then leave the bus idle
    task automatic program_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic [31:0] v, input logic last);
        while (!steady && $urandom_range(99) < 16) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= '{value: v, frame_last: last};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        phase_sent++;
    endtask

    // stop offering, let every pending box come out, then cover parser latency
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_box();
        logic signed [15:0] whole;
        logic [31:0]        v;
        whole = 16'($urandom_range(4000)) - 16'sd2000;
        case ($urandom_range(7))
            0: v = $urandom;
            1: v = EDGE_VALUES[$urandom_range(3)];
            default: v = {whole, 16'($urandom)};
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_objectness(input logic [31:0] th);
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = $urandom;
            1: v = th;
            2: v = th + 32'd1;
            3: v = th - 32'd1;
            4: v = 32'd0 - $urandom_range(65536);
            5: v = 32'h7FFF_FFFF;
            default: v = th + 32'd1 + $urandom_range(65536);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_score(input logic [31:0] prev);
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = $urandom;
            1: v = prev;
            2: v = 32'd0 - $urandom_range(65536, 1);
            3: v = 32'h0001_0000;
            default: v = $urandom_range(65536);
        endcase
        return v;
    endfunction

    // one row; some end early on a frame boundary, an open row stops
    // mid-way without frame_last so the next class count applies to it
    task automatic send_row(input int n_used, input logic [31:0] th, input bit open_end);
        int          len;
        int          cut;
        logic [31:0] prev;
        logic [31:0] v;
        logic        last;
        len = BOX_FIELDS + n_used;
        if (open_end || $urandom_range(9) == 0) begin
            cut = $urandom_range(len - 2);
        end else begin
            cut = len - 1;
        end
        prev = '0;
        for (int k = 0; k <= cut; k++) begin
            if (k < POS_OBJ) begin
                v = rand_box();
            end else if (k == POS_OBJ) begin
                v = rand_objectness(th);
            end else begin
                v = rand_score(prev);
                prev = v;
            end
            last = (k == cut) && !open_end && ((cut != len - 1) || $urandom_range(3) == 0);
            send_item(v, last);
        end
    endtask

    // receiver: random idling, one long hold-off, no idling in the steady phase
    initial begin : result_drain
        int stall_left;
        bit stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req && !stall_done && stall_left == 0) begin
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) stall_done = 1'b1;
                pop <= 1'b0;
            end else if (steady) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= 16);
            end
        end
    end

    initial begin : timeout
        #(TIMEOUT_NS);
        $display("detection_row_decoder_unit_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int          cls;
        int          n_used;
        logic [31:0] th;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_reg(ADDR_NUM_CLASSES, 32'd2);
        program_reg(ADDR_THRESHOLD, 32'd0);
        foreach (CORNER_VALUES[k]) begin
            send_item(CORNER_VALUES[k], k == 23);
        end
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            cls = PHASE_CLASSES[p];
            th = (p == RANDOM_TH_PHASE) ? $urandom_range(65536) : PHASE_THRESH[p];
            n_used = (cls == 0) ? 1 : ((cls > CLASS_LIMIT) ? CLASS_LIMIT : cls);
            // upper bits beyond the register width are sometimes set
            program_reg(ADDR_NUM_CLASSES,
                        {($urandom_range(1) ? 24'($urandom) : 24'd0), 8'(cls)});
            program_reg(ADDR_THRESHOLD,
                        {($urandom_range(1) ? 15'($urandom) : 15'd0), 17'(th)});
            steady = (p == STEADY_PHASE);
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS[p]) begin
                if (p == STALL_PHASE && phase_sent > 40) stall_req = 1'b1;
                send_row(n_used, th, 1'b0);
            end
            send_row(n_used, th, 1'b1);
            wait_idle();
            steady = 1'b0;
        end

        if (errors == 0) begin
            $display("detection_row_decoder_unit_tb: clean");
        end else begin
            $display("detection_row_decoder_unit_tb: errors");
        end
        $finish;
    end

endmodule
